// File: hdl/tpp_pkg.sv
// shared constants for the trapezoidal profile position block
`timescale 1ns / 1ps

package tpp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 2 * TIME_W;
   localparam int SQ_W      = TIME_W + 16;
   localparam int DNUM_W    = TIME_W + 17;
   localparam int D_W       = TIME_W + 1;
   localparam int ED_W      = 2 * D_W;
   localparam int REM_W     = ED_W + FRAC_BITS + 1;
   localparam int CNT_W     = 6;
   localparam int NSTAGE    = FRAC_BITS + 5;

   localparam logic [FRAC_BITS:0] FULL_SCALE = FRAC_W'(1) << FRAC_BITS;

   localparam logic [TIME_W-1:0] MOVE_DUR_RST    = 32'd65536;
   localparam logic [TIME_W-1:0] VEL_LIMIT_RST   = 32'd65536;
   localparam logic [TIME_W-1:0] PATH_SPAN_RST   = 32'd0;
   localparam logic [TIME_W-1:0] ZERO_PATH_LIMIT = 32'd7;

   localparam logic [CSR_IDX_W-1:0] REG_MOVE_DUR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATH_SPAN = 2'd2;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_FULL   = 3'd0;
   localparam mode_type MODE_LINE   = 3'd1;
   localparam mode_type MODE_ACCEL  = 3'd2;
   localparam mode_type MODE_CRUISE = 3'd3;
   localparam mode_type MODE_DECEL  = 3'd4;

endpackage

// File: hdl/trapezoidal_profile_position.sv
// trapezoidal profile position: travelled fraction of a fixed-duration move
//
// requests carry req_time_now (Q16.16 s) on a valid/ready channel; each request
// gives one result on rsp_* (fraction Q1.16 with 65536 = 1.0, velocity_adjusted,
// zero_path). csr_we/csr_index/csr_wdata write the move duration, the velocity
// limit and the path length; write only while no request is in flight.
// the pipe has three setup stages, one numerator stage, then one restoring divide
// stage per quotient bit, the last merged into the output register. one request
// enters per cycle unless rsp_ready stalls the output or the constants rebuild.
// after reset and after every register write the derived profile constants
// (cruise time by a bit-serial divide unless the velocity is clamped, then a
// shift-add product) are rebuilt; req_ready is low meanwhile. a stalled rsp_ready
// holds the output; bubbles in the pipe still close up, so requests keep entering
// until every stage is full.
`timescale 1ns / 1ps

module trapezoidal_profile_position (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tpp_pkg::TIME_W-1:0]          req_time_now,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tpp_pkg::FRAC_BITS:0]         rsp_fraction,
   output logic                                rsp_velocity_adjusted,
   output logic                                rsp_zero_path,
   input  logic                                csr_we,
   input  logic [tpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpp_pkg::TIME_W-1:0]          csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PROD  = 3'd1;
   localparam logic [2:0] ST_CLAMP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MINIT = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;

   localparam int F  = tpp_pkg::FRAC_BITS;
   localparam int NS = tpp_pkg::NSTAGE;
   localparam int RW = tpp_pkg::REM_W;

   // configuration and derived constants
   logic [tpp_pkg::TIME_W-1:0] move_dur_ff, vel_limit_ff, path_span_ff;
   logic [2:0]                 state_ff;
   logic [tpp_pkg::PROD_W-1:0] prod_ff;
   logic [tpp_pkg::CNT_W-1:0]  cnt_ff;
   logic [tpp_pkg::D_W-1:0]    drem_ff;
   logic [tpp_pkg::DNUM_W-1:0] dnum_ff;
   logic [tpp_pkg::D_W-1:0]    d_ff;
   logic [tpp_pkg::ED_W-1:0]   ed_ff, mcand_ff;
   logic [tpp_pkg::D_W-1:0]    mplier_ff;
   logic                       adj_ff;

   logic [tpp_pkg::SQ_W-1:0]   sq_w;
   logic [tpp_pkg::D_W-1:0]    e_w, rsh_w;
   logic                       ge_w, zp_w;

   assign sq_w  = {path_span_ff, 16'd0};
   assign e_w   = {move_dur_ff, 1'b0} - d_ff;
   assign rsh_w = {drem_ff[tpp_pkg::TIME_W-1:0], dnum_ff[tpp_pkg::DNUM_W-1]};
   assign ge_w  = rsh_w >= {1'b0, vel_limit_ff};
   assign zp_w  = path_span_ff < tpp_pkg::ZERO_PATH_LIMIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_dur_ff  <= tpp_pkg::MOVE_DUR_RST;
         vel_limit_ff <= tpp_pkg::VEL_LIMIT_RST;
         path_span_ff <= tpp_pkg::PATH_SPAN_RST;
         state_ff     <= ST_PROD;
      end else if (csr_we) begin
         unique case (csr_index)
            tpp_pkg::REG_MOVE_DUR:  move_dur_ff  <= csr_wdata;
            tpp_pkg::REG_VEL_LIMIT: vel_limit_ff <= csr_wdata;
            tpp_pkg::REG_PATH_SPAN: path_span_ff <= csr_wdata;
            default: ;
         endcase
         state_ff <= ST_PROD;
      end else begin
         unique case (state_ff)
            ST_IDLE: ;
            ST_PROD: begin
               prod_ff  <= tpp_pkg::PROD_W'(vel_limit_ff) * tpp_pkg::PROD_W'(move_dur_ff);
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               if (prod_ff < tpp_pkg::PROD_W'(sq_w)) begin
                  d_ff     <= {move_dur_ff, 1'b0};
                  adj_ff   <= 1'b1;
                  state_ff <= ST_MINIT;
               end else if (prod_ff > tpp_pkg::PROD_W'({sq_w, 1'b0})) begin
                  d_ff     <= tpp_pkg::D_W'(move_dur_ff);
                  adj_ff   <= 1'b1;
                  state_ff <= ST_MINIT;
               end else begin
                  adj_ff   <= 1'b0;
                  drem_ff  <= '0;
                  d_ff     <= '0;
                  dnum_ff  <= {path_span_ff, 17'd0};
                  cnt_ff   <= tpp_pkg::CNT_W'(tpp_pkg::DNUM_W);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               drem_ff <= ge_w ? rsh_w - {1'b0, vel_limit_ff} : rsh_w;
               d_ff    <= {d_ff[tpp_pkg::D_W-2:0], ge_w};
               dnum_ff <= dnum_ff << 1;
               cnt_ff  <= cnt_ff - tpp_pkg::CNT_W'(1);
               if (cnt_ff == tpp_pkg::CNT_W'(1)) begin
                  state_ff <= ST_MINIT;
               end
            end
            ST_MINIT: begin
               ed_ff     <= '0;
               mcand_ff  <= tpp_pkg::ED_W'(e_w);
               mplier_ff <= d_ff;
               cnt_ff    <= tpp_pkg::CNT_W'(tpp_pkg::D_W);
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               if (mplier_ff[0]) begin
                  ed_ff <= ed_ff + mcand_ff;
               end
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               cnt_ff    <= cnt_ff - tpp_pkg::CNT_W'(1);
               if (cnt_ff == tpp_pkg::CNT_W'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // pipeline control
   logic [NS-1:0] vld_ff;
   logic [NS:0]   en_w;
   logic          accept_w;

   assign en_w[NS] = rsp_ready;
   for (genvar i = 0; i < NS; i++) begin : g_en
      assign en_w[i] = !vld_ff[i] || en_w[i+1];
   end

   assign req_ready = en_w[0] && (state_ff == ST_IDLE) && !csr_we;
   assign accept_w  = req_valid && req_ready;
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en_w[0]) begin
            vld_ff[0] <= accept_w;
         end
         for (int i = 1; i < NS; i++) begin
            if (en_w[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage 0: sample
   logic [tpp_pkg::TIME_W-1:0] t0_ff;
   always_ff @(posedge clock) begin
      if (en_w[0]) begin
         t0_ff <= req_time_now;
      end
   end

   // stage 1: phase select
   tpp_pkg::mode_type          mode1_ff, mode_w;
   logic [tpp_pkg::TIME_W-1:0] t1_ff, x1_ff;
   logic [tpp_pkg::D_W-1:0]    two_t_w;

   assign two_t_w = {t0_ff, 1'b0};

   always_comb begin
      if (move_dur_ff == '0 || t0_ff > move_dur_ff) begin
         mode_w = tpp_pkg::MODE_FULL;
      end else if (e_w == '0) begin
         mode_w = tpp_pkg::MODE_LINE;
      end else if (two_t_w <= e_w) begin
         mode_w = tpp_pkg::MODE_ACCEL;
      end else if (two_t_w <= d_ff) begin
         mode_w = tpp_pkg::MODE_CRUISE;
      end else begin
         mode_w = tpp_pkg::MODE_DECEL;
      end
   end

   always_ff @(posedge clock) begin
      if (en_w[1]) begin
         mode1_ff <= mode_w;
         t1_ff    <= t0_ff;
         x1_ff    <= (mode_w == tpp_pkg::MODE_ACCEL) ? t0_ff : move_dur_ff - t0_ff;
      end
   end

   // stage 2: square
   tpp_pkg::mode_type          mode2_ff;
   logic [tpp_pkg::TIME_W-1:0] t2_ff;
   logic [tpp_pkg::PROD_W-1:0] sq2_ff;

   always_ff @(posedge clock) begin
      if (en_w[2]) begin
         mode2_ff <= mode1_ff;
         t2_ff    <= t1_ff;
         sq2_ff   <= tpp_pkg::PROD_W'(x1_ff) * tpp_pkg::PROD_W'(x1_ff);
      end
   end

   // divide pipe: stage p[0] holds numerator and divisor
   tpp_pkg::mode_type        mode_p_ff [0:F];
   logic [RW-1:0]            rem_p_ff  [0:F];
   logic [tpp_pkg::ED_W-1:0] div_p_ff  [0:F];
   logic [F-1:0]             q_p_ff    [0:F];

   logic [RW-1:0]            num_w;
   logic [tpp_pkg::ED_W-1:0] den_w;
   logic [tpp_pkg::D_W:0]    cru_w;

   assign cru_w = {t2_ff, 2'b00} - {1'b0, e_w};

   always_comb begin
      case (mode2_ff)
         tpp_pkg::MODE_LINE: begin
            num_w = RW'(t2_ff) << F;
            den_w = tpp_pkg::ED_W'(move_dur_ff);
         end
         tpp_pkg::MODE_ACCEL, tpp_pkg::MODE_DECEL: begin
            num_w = RW'(sq2_ff) << (F + 1);
            den_w = ed_ff;
         end
         tpp_pkg::MODE_CRUISE: begin
            num_w = RW'(cru_w) << F;
            den_w = tpp_pkg::ED_W'({d_ff, 1'b0});
         end
         default: begin
            num_w = '0;
            den_w = tpp_pkg::ED_W'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_w[3]) begin
         mode_p_ff[0] <= mode2_ff;
         rem_p_ff[0]  <= num_w;
         div_p_ff[0]  <= den_w;
         q_p_ff[0]    <= '0;
      end
   end

   for (genvar j = 1; j <= F; j++) begin : g_div
      logic [RW:0] trial_w;
      assign trial_w = {1'b0, rem_p_ff[j-1]} - {1'b0, RW'(div_p_ff[j-1]) << (F - j + 1)};
      always_ff @(posedge clock) begin
         if (en_w[3+j]) begin
            mode_p_ff[j] <= mode_p_ff[j-1];
            div_p_ff[j]  <= div_p_ff[j-1];
            rem_p_ff[j]  <= trial_w[RW] ? rem_p_ff[j-1] : trial_w[RW-1:0];
            q_p_ff[j]    <= {q_p_ff[j-1][F-2:0], ~trial_w[RW]};
         end
      end
   end

   // output stage: last quotient bit, phase finish, limit, zero-path clear
   logic [RW:0]          trial_o_w;
   logic [F:0]           q_fin_w, frac_w;
   logic [F:0]           frac_ff;
   logic                 adj_o_ff, zp_o_ff;

   assign trial_o_w = {1'b0, rem_p_ff[F]} - {1'b0, RW'(div_p_ff[F])};
   assign q_fin_w   = {q_p_ff[F], ~trial_o_w[RW]};

   always_comb begin
      case (mode_p_ff[F])
         tpp_pkg::MODE_FULL:  frac_w = tpp_pkg::FULL_SCALE;
         tpp_pkg::MODE_DECEL: frac_w = (q_fin_w > tpp_pkg::FULL_SCALE) ? '0
                                       : tpp_pkg::FULL_SCALE - q_fin_w;
         default:             frac_w = q_fin_w;
      endcase
      if (frac_w > tpp_pkg::FULL_SCALE) begin
         frac_w = tpp_pkg::FULL_SCALE;
      end
      if (zp_w) begin
         frac_w = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_w[NS-1]) begin
         frac_ff  <= frac_w;
         adj_o_ff <= adj_ff && !zp_w;
         zp_o_ff  <= zp_w;
      end
   end

   assign rsp_fraction          = frac_ff;
   assign rsp_velocity_adjusted = adj_o_ff;
   assign rsp_zero_path         = zp_o_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (state_ff == ST_IDLE))
      else $error("request accepted while profile constants rebuild");

   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request channel open right after register write");

   a_frac_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fraction <= tpp_pkg::FULL_SCALE))
      else $error("fraction above full scale");

   a_zero_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_path) |-> (rsp_fraction == '0 && !rsp_velocity_adjusted))
      else $error("zero path result not cleared");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fraction)))
      else $error("stalled result changed");

endmodule

// File: tb/tpp_checker.sv
// request/result monitor with profile predictor and scoreboard for the profile block
`timescale 1ns / 1ps

module tpp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [tpp_pkg::TIME_W-1:0]      req_time_now,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [tpp_pkg::FRAC_BITS:0]     rsp_fraction,
   input  logic                            rsp_velocity_adjusted,
   input  logic                            rsp_zero_path,
   input  logic                            csr_we,
   input  logic [tpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tpp_pkg::TIME_W-1:0]      csr_wdata,
   output int                              errors,
   output int                              pending
);

   typedef struct packed {
      logic [tpp_pkg::FRAC_BITS:0] fraction;
      logic                        adjusted;
      logic                        zero_path;
   } setpoint_type;

   logic [tpp_pkg::TIME_W-1:0] move_time;
   logic [tpp_pkg::TIME_W-1:0] cruise_vel;
   logic [tpp_pkg::TIME_W-1:0] path_len;
   setpoint_type               setpoint_q[$];

   function automatic setpoint_type profile_fraction(
         input logic [tpp_pkg::TIME_W-1:0] t_in,
         input logic [tpp_pkg::TIME_W-1:0] t_total,
         input logic [tpp_pkg::TIME_W-1:0] vel,
         input logic [tpp_pkg::TIME_W-1:0] len);
      logic [127:0] t, tt, s, v, sq, prod, d, e, frac, r, q, full, mask64;
      setpoint_type sp;
      t      = t_in;
      tt     = t_total;
      s      = len;
      v      = vel;
      full   = 128'(1) << tpp_pkg::FRAC_BITS;
      mask64 = {64'd0, {64{1'b1}}};
      sp     = '0;
      frac   = 0;
      if (s < tpp_pkg::ZERO_PATH_LIMIT) begin
         sp.zero_path = 1'b1;
      end else begin
         sq   = s << 16;
         prod = v * tt;
         if (prod < sq) begin
            d = 2 * tt;
            sp.adjusted = 1'b1;
         end else if (prod > 2 * sq) begin
            d = tt;
            sp.adjusted = 1'b1;
         end else begin
            d = (sq << 1) / v;
         end
         e = 2 * tt - d;
         if (tt == 0 || t > tt) begin
            frac = full;
         end else if (e == 0) begin
            frac = (t << tpp_pkg::FRAC_BITS) / tt;
         end else if (2 * t <= e) begin
            q    = (((t * t) << (tpp_pkg::FRAC_BITS + 1)) / e) & mask64;
            frac = q / d;
         end else if (2 * t <= d) begin
            frac = ((4 * t - e) << tpp_pkg::FRAC_BITS) / (2 * d);
         end else begin
            r    = tt - t;
            q    = (((r * r) << (tpp_pkg::FRAC_BITS + 1)) / e) & mask64;
            q    = q / d;
            frac = (q > full) ? 0 : full - q;
         end
         if (frac > full) frac = full;
      end
      sp.fraction = frac[tpp_pkg::FRAC_BITS:0];
      return sp;
   endfunction

   always @(posedge clock) begin
      setpoint_type want;
      int           miss;
      miss = 0;
      if (reset) begin
         move_time  <= tpp_pkg::MOVE_DUR_RST;
         cruise_vel <= tpp_pkg::VEL_LIMIT_RST;
         path_len   <= tpp_pkg::PATH_SPAN_RST;
         setpoint_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               tpp_pkg::REG_MOVE_DUR:  move_time  <= csr_wdata;
               tpp_pkg::REG_VEL_LIMIT: cruise_vel <= csr_wdata;
               tpp_pkg::REG_PATH_SPAN: path_len   <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (setpoint_q.size() == 0) begin
               miss++;
               $display("%0t: unexpected result fraction %0d", $time, rsp_fraction);
            end else begin
               want = setpoint_q.pop_front();
               if (want.fraction !== rsp_fraction) begin
                  miss++;
                  $display("%0t: fraction expected %0d actual %0d", $time,
                           want.fraction, rsp_fraction);
               end
               if (want.adjusted !== rsp_velocity_adjusted) begin
                  miss++;
                  $display("%0t: velocity_adjusted expected %0b actual %0b", $time,
                           want.adjusted, rsp_velocity_adjusted);
               end
               if (want.zero_path !== rsp_zero_path) begin
                  miss++;
                  $display("%0t: zero_path expected %0b actual %0b", $time,
                           want.zero_path, rsp_zero_path);
               end
            end
         end
         if (req_valid && req_ready)
            setpoint_q.push_back(profile_fraction(req_time_now, move_time, cruise_vel,
                                                  path_len));
         errors <= errors + miss;
      end
      pending <= setpoint_q.size();
   end

   initial errors = 0;

endmodule

// File: tb/tb_top.sv
// stimulus, idling and verdict for the trapezoidal profile position block
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 5000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [tpp_pkg::TIME_W-1:0]        req_time_now = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [tpp_pkg::FRAC_BITS:0]       rsp_fraction;
   logic                              rsp_velocity_adjusted;
   logic                              rsp_zero_path;
   logic                              csr_we = 1'b0;
   logic [tpp_pkg::CSR_IDX_W-1:0]     csr_index = tpp_pkg::REG_MOVE_DUR;
   logic [tpp_pkg::TIME_W-1:0]        csr_wdata = '0;
   int                                errors;
   int                                pending;
   int                                idle_cycles = 0;
   bit                                burst_mode = 0;
   bit                                hold_rsp = 0;
   logic [tpp_pkg::TIME_W-1:0]        cur_time;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   trapezoidal_profile_position u_top (.*);

   tpp_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stall per result outside burst mode, one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         stall = burst_mode ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_request(input logic [tpp_pkg::TIME_W-1:0] t);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_time_now = t;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input logic [tpp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tpp_pkg::TIME_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_profile(input logic [tpp_pkg::TIME_W-1:0] t_total,
                              input logic [tpp_pkg::TIME_W-1:0] vel,
                              input logic [tpp_pkg::TIME_W-1:0] len);
      drain();
      write_reg(tpp_pkg::REG_MOVE_DUR, t_total);
      write_reg(tpp_pkg::REG_VEL_LIMIT, vel);
      write_reg(tpp_pkg::REG_PATH_SPAN, len);
      cur_time = t_total;
   endtask

   function automatic logic [tpp_pkg::TIME_W-1:0] pick_time(
         input logic [tpp_pkg::TIME_W-1:0] t_total);
      logic [63:0] span;
      int          sel;
      sel  = $urandom_range(0, 99);
      span = t_total;
      if (sel < 10) return $urandom();
      else if (sel < 18) return t_total + $urandom_range(0, 3);
      else if (sel < 24) return t_total - $urandom_range(0, 2);
      else if (sel < 28) return $urandom_range(0, 2);
      else if (sel < 34) return (t_total >> $urandom_range(1, 3)) + $urandom_range(0, 2) - 1;
      else if (sel < 40) return 32'((span * 64'($urandom_range(0, 1000))) / 1000 + span / 16);
      else return 32'((span * 64'($urandom())) >> 32);
   endfunction

   task automatic random_profile;
      logic [tpp_pkg::TIME_W-1:0] t_total, len, vel;
      logic [63:0]                avg;
      int                         sel;
      sel = $urandom_range(0, 9);
      t_total = (sel < 2) ? $urandom_range(1, 300) : (sel < 4) ? 32'hFFFF_FFFF - $urandom_range(0, 5)
              : (sel < 7) ? $urandom_range(32'h0000_4000, 32'h000A_0000) : $urandom();
      if (t_total == 0) t_total = 1;
      sel = $urandom_range(0, 9);
      len = (sel == 0) ? $urandom_range(0, 8) : (sel == 1) ? 32'hFFFF_FFFF
          : (sel < 5) ? $urandom_range(7, 32'h0010_0000) : $urandom();
      avg = ({32'd0, len} << 16) / t_total;
      sel = $urandom_range(0, 9);
      case (sel)
         0: vel = 0;
         1: vel = 32'hFFFF_FFFF;
         2: vel = (avg > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(avg);
         3: vel = (avg > 32'hFFFF_FFFF) ? $urandom() : 32'(avg / 2);
         4: vel = (avg * 3 > 32'hFFFF_FFFF) ? $urandom() : 32'(avg * 3);
         5, 6, 7: vel = (avg * 2 > 32'hFFFF_FFFF) ? $urandom()
                     : 32'(avg + 64'($urandom_range(0, 1000)) * avg / 1000);
         default: vel = $urandom();
      endcase
      set_profile(t_total, vel, len);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      cur_time = tpp_pkg::MOVE_DUR_RST;
      // reset profile: zero path
      send_request(32'd0);
      send_request(32'hFFFF_FFFF);
      // cruise at exactly the average speed
      set_profile(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_request(32'd0);
      send_request(32'h0000_8000);
      send_request(32'h0001_0000);
      send_request(32'h0001_0001);
      // interior velocity with all three phases
      set_profile(32'h0002_0000, 32'h0001_8000, 32'h0002_0000);
      send_request(32'd1);
      send_request(32'h0000_4000);
      send_request(32'h0000_8000);
      send_request(32'h0001_0000);
      send_request(32'h0001_C000);
      send_request(32'h0001_FFFF);
      // clamp low, clamp high, path threshold, extremes
      set_profile(32'h0001_0000, 32'd0, 32'd7);
      send_request(32'h0000_3000);
      send_request(32'h0000_C000);
      set_profile(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000);
      send_request(32'h0000_1000);
      send_request(32'h0000_8000);
      set_profile(32'h0001_0000, 32'h0001_0000, 32'd6);
      send_request(32'h0000_8000);
      set_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'h7FFF_FFFF);
      send_request(32'hFFFF_FFFE);
      set_profile(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'd1);
      send_request(32'd2);

      for (int ph = 0; ph < 14; ph++) begin
         random_profile();
         for (int k = 0; k < 95; k++) begin
            if (k % 30 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (ph == 3 && k == 10) hold_rsp = 1;
            if (ph == 6 && k == 40) drain();
            send_request(pick_time(cur_time));
         end
      end

      burst_mode = 0;
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
